@@ rtl/bsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// bsrs_pkg: shared types and constants
// Field widths and request mode codes for the bounded set with rank select.
// ----------------------------------------------------------------------------
package bsrs_pkg;

  localparam int MODE_W = 2;   // request mode
  localparam int VAL_W  = 32;  // item value on the ports
  localparam int RANK_W = 5;   // rank field
  localparam int CNT_W  = 6;   // item count and capacity

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 2'd0,
    MODE_ERASE    = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_GET      = 2'd3
  } mode_t;

endpackage

@@ rtl/bsrs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bsrs_cfg_if: capacity register write channel
// Valid/ready channel carrying the new capacity value.
// ----------------------------------------------------------------------------
interface bsrs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bsrs_pkg::CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bsrs_req_if.sv @@
// ----------------------------------------------------------------------------
// bsrs_req_if: request channel
// Valid/ready channel carrying mode, item value and rank.
// ----------------------------------------------------------------------------
interface bsrs_req_if;
  logic                        valid;
  logic                        ready;
  bsrs_pkg::mode_t             mode;
  logic [bsrs_pkg::VAL_W-1:0]  item_value;
  logic [bsrs_pkg::RANK_W-1:0] rank;

  modport source (output valid, output mode, output item_value, output rank, input ready);
  modport sink   (input valid, input mode, input item_value, input rank, output ready);
endinterface

@@ rtl/bsrs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bsrs_rsp_if: result channel
// Valid/ready channel carrying ok, read value, count and empty flag.
// ----------------------------------------------------------------------------
interface bsrs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [bsrs_pkg::VAL_W-1:0] read_value;
  logic [bsrs_pkg::CNT_W-1:0] count;
  logic                       is_empty;

  modport source (output valid, output ok, output read_value, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input read_value, input count,
                  input is_empty, output ready);
endinterface

@@ rtl/bsrs_ram.sv @@
// ----------------------------------------------------------------------------
// bsrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bounded_set_with_rank_select_core.sv @@
// ----------------------------------------------------------------------------
// bounded_set_with_rank_select_core: bounded set of distinct values
// Compacted, unordered table in one RAM; insert, erase, contains and
// get-by-rank requests, each answered by one result.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  cfg     | in  | valid/ready | data (capacity, 6 bits)
//  req     | in  | valid/ready | mode, item_value, rank
//  rsp     | out | valid/ready | ok, read_value, count, is_empty
//
//  One request at a time; the single RAM read port sets the pace, one entry
//  per cycle. Insert, contains and a missed erase scan the table, stopping
//  at a hit; a found erase then closes the gap, reading the entries past
//  the hit; get makes one full counting pass per candidate, stopping at
//  the match; a rank out of range answers without reading the table.
//  A new request is taken while the previous result waits in rsp; the result
//  is held in rsp until taken. Reset (rst, synchronous) empties the set and
//  sets the capacity to 32; table contents are not cleared. cfg is always
//  ready.
//
module bounded_set_with_rank_select_core #(
  parameter int SET_DEPTH  = 32,
  parameter int ITEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  bsrs_cfg_if.sink    cfg,
  bsrs_req_if.sink    req,
  bsrs_rsp_if.source  rsp
);

  localparam int AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = bsrs_pkg::CNT_W;
  localparam int VAL_W = bsrs_pkg::VAL_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,  // waiting for a request
    ST_SCAN  = 7'b0000010,  // linear search for val_q
    ST_SHIFT = 7'b0000100,  // erase: close the gap
    ST_GLOAD = 7'b0001000,  // get: read candidate
    ST_GCAND = 7'b0010000,  // get: latch candidate
    ST_GCNT  = 7'b0100000,  // get: count smaller entries
    ST_FIN   = 7'b1000000   // hand result to output register
  } state_t;

  state_t                 state;

  // architectural state
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       capacity;

  // latched request
  bsrs_pkg::mode_t        mode_q;
  logic [ITEM_WIDTH-1:0]  val_q;
  logic [CNT_W-1:0]       rank_q;

  // scan control: idx is the next address to read, chk marks a read in
  // flight whose data shows on ram_rdata this cycle, chk_idx its address
  logic [CNT_W-1:0]       idx;
  logic                   chk;
  logic [CNT_W-1:0]       chk_idx;

  // rank select
  logic [CNT_W-1:0]       oj;      // candidate index
  logic [ITEM_WIDTH-1:0]  cand;
  logic [CNT_W-1:0]       less;

  // pending result
  logic                   res_ok;
  logic [VAL_W-1:0]       res_val;

  // output register
  logic                   rsp_valid;
  logic                   rsp_ok;
  logic [VAL_W-1:0]       rsp_val;
  logic [CNT_W-1:0]       rsp_count;
  logic                   rsp_empty;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ITEM_WIDTH-1:0]  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [ITEM_WIDTH-1:0]  ram_rdata;

  logic                   req_fire;
  logic                   hit;
  logic                   scan_end;
  logic                   room;
  logic [CNT_W-1:0]       less_upd;
  logic                   out_free;

  assign req.ready   = (state == ST_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign cfg.ready   = 1'b1;

  assign hit      = chk && (ram_rdata == val_q);
  assign scan_end = (idx == count);
  // capacity saturates at the table depth
  assign room     = (count < capacity) && (32'(count) < SET_DEPTH);
  assign less_upd = less + CNT_W'(chk && (cand > ram_rdata));
  assign out_free = !rsp_valid || rsp.ready;

  bsrs_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (SET_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = val_q;
    ram_raddr = AW'(idx);
    case (state)
      ST_SCAN: begin
        // insert of an absent value appends at the end of the table
        if (!hit && scan_end && mode_q == bsrs_pkg::MODE_INSERT && room) begin
          ram_we = 1'b1;
        end
      end
      ST_SHIFT: begin
        // entry read last cycle moves down one place
        ram_we    = chk;
        ram_waddr = AW'(chk_idx);
        ram_wdata = ram_rdata;
      end
      ST_GLOAD: begin
        ram_raddr = AW'(oj);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      capacity  <= CNT_W'(32);
      chk       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      // in ST_FIN a free slot is refilled below instead
      if (rsp_valid && rsp.ready && state != ST_FIN) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            mode_q  <= req.mode;
            val_q   <= ITEM_WIDTH'(req.item_value);
            rank_q  <= CNT_W'(req.rank);
            idx     <= '0;
            chk     <= 1'b0;
            oj      <= '0;
            res_ok  <= 1'b0;
            res_val <= '0;
            if (req.mode == bsrs_pkg::MODE_GET) begin
              // rank out of range answers at once
              state <= (CNT_W'(req.rank) < count) ? ST_GLOAD : ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (hit) begin
            chk <= 1'b0;
            case (mode_q)
              bsrs_pkg::MODE_ERASE: begin
                idx   <= chk_idx + CNT_W'(1);
                state <= ST_SHIFT;
              end
              bsrs_pkg::MODE_CONTAINS: begin
                res_ok <= 1'b1;
                state  <= ST_FIN;
              end
              default: begin
                // insert of a value already present
                state <= ST_FIN;
              end
            endcase
          end else if (scan_end) begin
            chk <= 1'b0;
            if (mode_q == bsrs_pkg::MODE_INSERT && room) begin
              count  <= count + CNT_W'(1);
              res_ok <= 1'b1;
            end
            state <= ST_FIN;
          end else begin
            chk     <= 1'b1;
            chk_idx <= idx;
            idx     <= idx + CNT_W'(1);
          end
        end

        ST_SHIFT: begin
          if (idx < count) begin
            chk     <= 1'b1;
            chk_idx <= idx - CNT_W'(1);
            idx     <= idx + CNT_W'(1);
          end else begin
            chk <= 1'b0;
            if (!chk) begin
              count  <= count - CNT_W'(1);
              res_ok <= 1'b1;
              state  <= ST_FIN;
            end
          end
        end

        ST_GLOAD: begin
          state <= ST_GCAND;
        end

        ST_GCAND: begin
          cand  <= ram_rdata;
          idx   <= '0;
          chk   <= 1'b0;
          less  <= '0;
          state <= ST_GCNT;
        end

        ST_GCNT: begin
          if (scan_end) begin
            chk <= 1'b0;
            if (less_upd == rank_q) begin
              res_ok  <= 1'b1;
              res_val <= VAL_W'(cand);
              state   <= ST_FIN;
            end else begin
              oj    <= oj + CNT_W'(1);
              state <= ST_GLOAD;
            end
          end else begin
            chk  <= 1'b1;
            idx  <= idx + CNT_W'(1);
            less <= less_upd;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp_ok    <= res_ok;
            rsp_val   <= res_val;
            rsp_count <= count;
            rsp_empty <= (count == '0);
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.ok         = rsp_ok;
  assign rsp.read_value = rsp_val;
  assign rsp.count      = rsp_count;
  assign rsp.is_empty   = rsp_empty;

endmodule

@@ verif/bounded_set_with_rank_select_core_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_set_with_rank_select_core_tb: self-checking bench for the set core
// Drives insert, erase, contains and rank requests through the valid/ready
// channels. A behavioural copy of the set predicts every result, and results
// are compared field by field as they leave the core. Capacity is changed
// between phases, and random idling and a long result hold-off are applied.
// ----------------------------------------------------------------------------
module bounded_set_with_rank_select_core_tb;

  localparam int DEPTH     = 32;   // table depth of the core under test
  localparam int POOL_SIZE = 40;   // small value pool so requests hit the set
  localparam int HALF_CLK  = 5;

  // one result as the core reports it
  typedef struct packed {
    logic                       ok;
    logic [bsrs_pkg::VAL_W-1:0] read_value;
    logic [bsrs_pkg::CNT_W-1:0] count;
    logic                       is_empty;
  } set_result_t;

  logic clk;
  logic rst;

  bsrs_cfg_if cfg_bus ();
  bsrs_req_if req_bus ();
  bsrs_rsp_if rsp_bus ();

  bounded_set_with_rank_select_core DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the set: compacted, unordered, entries below held_count.
  // Updated at the edge where the core accepts a request.
  // --------------------------------------------------------------------------
  logic [bsrs_pkg::VAL_W-1:0] held_items [DEPTH];
  int unsigned                held_count;
  logic [bsrs_pkg::CNT_W-1:0] capacity_reg;

  set_result_t                awaited_results [$];  // oldest at the front
  logic [bsrs_pkg::VAL_W-1:0] value_pool [POOL_SIZE];

  int  errors;
  int  results_seen;
  int  mode_tally [4];
  bit  gaps_on;       // random idling on both channels
  bit  req_offered;   // req valid currently driven high by the bench
  bit  hold_off;      // long receiver stall, see hold_results
  int  stall_left;

  // --------------------------------------------------------------------------
  // Clock, reset, initial drive
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #HALF_CLK clk = ~clk;
  end

  // safety net: comfortably beyond the slowest legal run
  initial begin
    #26_000_000;
    $display("FAIL bounded_set_with_rank_select_core");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: applies one request to the bench copy, returns its result.
  // --------------------------------------------------------------------------
  function automatic set_result_t apply_request(bsrs_pkg::mode_t m,
                                                logic [bsrs_pkg::VAL_W-1:0] v,
                                                logic [bsrs_pkg::RANK_W-1:0] r);
    set_result_t res;
    int unsigned pos;
    int unsigned limit;
    int unsigned less;
    res   = '0;
    pos   = held_count;
    // capacity above the table depth saturates at the depth
    limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    for (int i = 0; i < held_count; i++) begin
      if (pos == held_count && held_items[i] == v) pos = i;
    end
    case (m)
      bsrs_pkg::MODE_INSERT: begin
        // duplicates and a full set (capacity zero included) leave it as is
        if (pos == held_count && held_count < limit) begin
          held_items[held_count] = v;
          held_count++;
          res.ok = 1'b1;
        end
      end
      bsrs_pkg::MODE_ERASE: begin
        // close the gap; the old last entry is never read past the end
        if (pos < held_count) begin
          for (int j = pos; j + 1 < held_count; j++) held_items[j] = held_items[j + 1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      bsrs_pkg::MODE_CONTAINS: begin
        res.ok = (pos < held_count);
      end
      default: begin
        // rank r = the item greater than exactly r others; rank >= count fails
        if (r < held_count) begin
          for (int j = 0; j < held_count; j++) begin
            less = 0;
            for (int k = 0; k < held_count; k++) begin
              if (held_items[j] > held_items[k]) less++;
            end
            if (less == r) begin
              res.ok         = 1'b1;
              res.read_value = held_items[j];
            end
          end
        end
      end
    endcase
    res.count    = bsrs_pkg::CNT_W'(held_count);
    res.is_empty = (held_count == 0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: checks each accepted result, then drives ready for the
  // next edge (hold-off, random stall bursts, or plain ready).
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [bsrs_pkg::VAL_W-1:0] want,
                                      logic [bsrs_pkg::VAL_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got ok %0b value %0h count %0d",
                 $time, rsp_bus.ok, rsp_bus.read_value, rsp_bus.count);
      end else begin
        want = awaited_results.pop_front();
        check_field("ok", bsrs_pkg::VAL_W'(want.ok), bsrs_pkg::VAL_W'(rsp_bus.ok));
        check_field("read_value", want.read_value, rsp_bus.read_value);
        check_field("count", bsrs_pkg::VAL_W'(want.count),
                    bsrs_pkg::VAL_W'(rsp_bus.count));
        check_field("is_empty", bsrs_pkg::VAL_W'(want.is_empty),
                    bsrs_pkg::VAL_W'(rsp_bus.is_empty));
        results_seen++;
      end
    end
    if (hold_off) begin
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);   // start a stall burst; stall_left holds the rest of it
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // drop req valid, but only if it is high, so valid never gets two updates
  task automatic quiet_requests();
    if (req_offered) begin
      req_bus.valid <= 1'b0;
      req_offered = 1'b0;
    end
  endtask

  // valid is left high after the handshake; the next request either
  // follows in the same step or calls quiet_requests first
  task automatic send_request(bsrs_pkg::mode_t m, logic [bsrs_pkg::VAL_W-1:0] v,
                              logic [bsrs_pkg::RANK_W-1:0] r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      quiet_requests();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.mode       <= m;
    req_bus.item_value <= v;
    req_bus.rank       <= r;
    req_offered = 1'b1;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    awaited_results.push_back(apply_request(m, v, r));
    mode_tally[m]++;
  endtask

  task automatic drain_results();
    quiet_requests();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // only ever called with requests in between, so cfg valid is set once
  // per step
  task automatic write_capacity(logic [bsrs_pkg::CNT_W-1:0] cap);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cap;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    capacity_reg = cap;
  endtask

  // long receiver stall, counted here rather than in the ready process
  task automatic hold_results(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // mostly values that are held or in the pool, some fully random
  function automatic logic [bsrs_pkg::VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (held_count > 0 && sel < 4) return held_items[$urandom_range(0, held_count - 1)];
    if (sel < 8) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic send_random_request();
    bsrs_pkg::mode_t             m;
    logic [bsrs_pkg::RANK_W-1:0] r;
    int                          sel;
    sel = $urandom_range(0, 19);
    if (sel < 7)       m = bsrs_pkg::MODE_INSERT;
    else if (sel < 12) m = bsrs_pkg::MODE_ERASE;
    else if (sel < 16) m = bsrs_pkg::MODE_CONTAINS;
    else               m = bsrs_pkg::MODE_GET;
    // ranks mostly in range, now and then anywhere in the field
    if (held_count > 0 && $urandom_range(0, 3) != 0) begin
      r = bsrs_pkg::RANK_W'($urandom_range(0, held_count - 1));
    end else begin
      r = bsrs_pkg::RANK_W'($urandom_range(0, 31));
    end
    send_request(m, pick_value(), r);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty-set answers, extremes of the value, duplicates, rank order,
  // erase of first and last entries
  task automatic test_basic_requests();
    send_request(bsrs_pkg::MODE_GET, '0, 5'd0);              // rank on an empty set
    send_request(bsrs_pkg::MODE_ERASE, 32'd5, '0);           // erase absent
    send_request(bsrs_pkg::MODE_CONTAINS, 32'd0, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h0000_0000, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'hFFFF_FFFF, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h0000_0000, '0);  // already present
    send_request(bsrs_pkg::MODE_INSERT, 32'h8000_0000, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h7FFF_FFFF, '0);
    send_request(bsrs_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, '0);
    send_request(bsrs_pkg::MODE_CONTAINS, 32'd1, '0);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd0);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd1);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd2);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd3);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd4);              // rank == count
    send_request(bsrs_pkg::MODE_GET, '0, 5'd31);
    send_request(bsrs_pkg::MODE_ERASE, 32'h7FFF_FFFF, '0);   // last entry
    send_request(bsrs_pkg::MODE_ERASE, 32'h0000_0000, '0);   // first entry, gap closes
    send_request(bsrs_pkg::MODE_ERASE, 32'h0000_0000, '0);   // now absent
    send_request(bsrs_pkg::MODE_GET, '0, 5'd0);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd1);
  endtask

  // capacity zero refuses even an empty set; capacity one takes one item
  task automatic test_small_capacity();
    while (held_count > 0) send_request(bsrs_pkg::MODE_ERASE, held_items[0], '0);
    write_capacity(6'd0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h1234_5678, '0);
    send_request(bsrs_pkg::MODE_CONTAINS, 32'h1234_5678, '0);
    write_capacity(6'd1);
    send_request(bsrs_pkg::MODE_INSERT, 32'hA5A5_5A5A, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h5A5A_A5A5, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'hA5A5_5A5A, '0);
  endtask

  // capacity 63 and 33 saturate at the depth; a capacity below the count
  // blocks inserts but not erases
  task automatic test_full_table();
    write_capacity(6'd63);
    while (held_count < DEPTH) send_request(bsrs_pkg::MODE_INSERT, $urandom(), '0);
    send_request(bsrs_pkg::MODE_INSERT, $urandom(), '0);     // table full
    send_request(bsrs_pkg::MODE_GET, '0, 5'd0);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd31);
    send_request(bsrs_pkg::MODE_CONTAINS, held_items[DEPTH - 1], '0);
    send_request(bsrs_pkg::MODE_ERASE, held_items[DEPTH - 1], '0);  // erase at the table end
    send_request(bsrs_pkg::MODE_ERASE, held_items[0], '0);
    send_request(bsrs_pkg::MODE_GET, '0, 5'd29);
    write_capacity(6'd33);
    send_request(bsrs_pkg::MODE_INSERT, 32'hFFFF_FFFF, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h0000_0000, '0);
    send_request(bsrs_pkg::MODE_INSERT, 32'h0000_0001, '0);
    write_capacity(6'd20);
    send_request(bsrs_pkg::MODE_INSERT, 32'h0000_0002, '0);
    send_request(bsrs_pkg::MODE_ERASE, held_items[5], '0);
  endtask

  // receiver stops for a long stretch while requests keep coming: the core
  // must stall req once its result slot is occupied and a further result waits
  task automatic test_result_backpressure();
    write_capacity(6'd32);
    gaps_on <= 1'b0;
    fork
      hold_results(200);
      begin
        repeat (12) send_random_request();
        quiet_requests();
      end
    join
    gaps_on <= 1'b1;
  endtask

  // random phases over a range of capacities; the last phase runs flat out
  task automatic test_random_mix();
    write_capacity(6'd32);
    repeat (60) send_random_request();
    write_capacity(6'd5);
    repeat (45) send_random_request();
    write_capacity(6'd0);
    repeat (25) send_random_request();
    write_capacity(bsrs_pkg::CNT_W'($urandom_range(0, 63)));
    repeat (55) send_random_request();
    write_capacity(6'd63);
    repeat (60) send_random_request();
    write_capacity(6'd32);
    gaps_on <= 1'b0;
    repeat (70) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.data       = '0;
    req_bus.valid      = 1'b0;
    req_bus.mode       = bsrs_pkg::MODE_INSERT;
    req_bus.item_value = '0;
    req_bus.rank       = '0;
    rsp_bus.ready      = 1'b0;
    held_count         = 0;
    capacity_reg       = 6'd32;   // reset value of the register
    errors             = 0;
    results_seen       = 0;
    mode_tally         = '{default: 0};
    gaps_on            = 1'b1;
    req_offered        = 1'b0;
    hold_off           = 1'b0;
    stall_left         = 0;
    value_pool[0]      = 32'h0000_0000;
    value_pool[1]      = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_small_capacity();
    test_full_table();
    test_result_backpressure();
    test_random_mix();

    drain_results();
    // anything the core emits now has no request behind it
    repeat (64) @(posedge clk);

    $display("Checked %0d results: %0d inserts, %0d erases, %0d contains, %0d rank reads",
             results_seen, mode_tally[bsrs_pkg::MODE_INSERT],
             mode_tally[bsrs_pkg::MODE_ERASE], mode_tally[bsrs_pkg::MODE_CONTAINS],
             mode_tally[bsrs_pkg::MODE_GET]);
    $display("Capacities 0 to 63 incl. saturation, full table, idling and long hold-off");
    if (errors == 0) begin
      $display("PASS bounded_set_with_rank_select_core");
    end else begin
      $display("FAIL bounded_set_with_rank_select_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bsrs_pkg.sv
rtl/bsrs_cfg_if.sv
rtl/bsrs_req_if.sv
rtl/bsrs_rsp_if.sv
rtl/bsrs_ram.sv
rtl/bounded_set_with_rank_select_core.sv
verif/bounded_set_with_rank_select_core_tb.sv
